>>> design/pmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared widths, codes and reset values of the particle mesh mass deposit.
// ----------------------------------------------------------------------------
package pmd_pkg;

   localparam int GRID_MAX_DEF = 64;
   localparam int SLAB_MAX_DEF = 64;

   localparam int POS_W      = 32;
   localparam int SCALE_W    = 32;
   localparam int VAL_W      = 32;
   localparam int CADDR_W    = 18;
   localparam int MODE_W     = 2;
   localparam int GSIZE_W    = 7;
   localparam int SSTART_W   = 6;
   localparam int SDEPTH_W   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int T_W        = 48;  // grid coordinate, Q.16
   localparam int WGT_W      = 17;  // weights reach 1.0 = 65536
   localparam int TAPS       = 3;

   localparam logic [MODE_W-1:0] MODE_NGP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CIC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TSC = 2'd2;

   localparam logic OP_DEPOSIT = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ASSIGN_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_DEPTH  = 3'd4;

   localparam logic [MODE_W-1:0]   MODE_RST   = MODE_CIC;
   localparam logic [GSIZE_W-1:0]  GSIZE_RST  = 7'd64;
   localparam logic [SCALE_W-1:0]  SCALE_RST  = 32'h0001_0000;
   localparam logic [SSTART_W-1:0] SSTART_RST = 6'd0;
   localparam logic [SDEPTH_W-1:0] SDEPTH_RST = 7'd64;

   localparam logic [WGT_W-1:0] ONE_Q16  = 17'h1_0000;
   localparam logic [WGT_W-1:0] TSC_MID  = 17'd49152;
   localparam logic [15:0]      HALF_Q16 = 16'h8000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_TAPS,
      ST_DRAIN,
      ST_RD_LIM,
      ST_RD_ISSUE,
      ST_RD_DATA
   } state_type;

endpackage

>>> design/pmd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pmd_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old content on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/pmd_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_axis
// Per-axis tap indices and weights for NGP, CIC and TSC from one grid
// coordinate, with one periodic wrap.
// ----------------------------------------------------------------------------
module pmd_axis #(
   parameter int  GRID_MAX = pmd_pkg::GRID_MAX_DEF,
   localparam int GW       = $clog2(GRID_MAX + 1),
   localparam int IW       = $clog2(GRID_MAX)
) (
   input  logic [pmd_pkg::T_W-1:0]    t_i,
   input  logic [pmd_pkg::MODE_W-1:0] mode_i,
   input  logic [GW-1:0]              g_i,
   output logic [IW-1:0]              idx_o [0:pmd_pkg::TAPS-1],
   output logic                       ok_o  [0:pmd_pkg::TAPS-1],
   output logic [pmd_pkg::WGT_W-1:0]  wgt_o [0:pmd_pkg::TAPS-1]
);
   import pmd_pkg::*;

   localparam int XW = 35;

   function automatic logic [XW-1:0] wrap(input logic [XW-1:0] v, input logic [XW-1:0] gg);
      logic [XW-1:0] res;
      if (v[XW-1]) begin
         res = v + gg;
      end else if (v >= gg) begin
         res = v - gg;
      end else begin
         res = v;
      end
      return res;
   endfunction

   logic [T_W:0]    r;
   logic [XW-1:0]   gx;
   logic [XW-1:0]   c_raw;
   logic [XW-1:0]   f_raw;
   logic [15:0]     frac;
   logic [15:0]     rfrac;
   logic [WGT_W-1:0] lo;
   logic [15:0]     ad;
   logic [31:0]     dd;
   logic [33:0]     lo2;
   logic [33:0]     hi2;
   logic [XW-1:0]   raw [0:TAPS-1];
   logic [XW-1:0]   wr  [0:TAPS-1];
   logic            use_tap [0:TAPS-1];

   assign r     = {1'b0, t_i} + (T_W + 1)'(HALF_Q16);
   assign gx    = XW'(g_i);
   assign c_raw = XW'(r[T_W:16]);
   assign f_raw = XW'(t_i[T_W-1:16]);
   assign frac  = t_i[15:0];
   assign rfrac = r[15:0];
   assign lo    = ONE_Q16 - WGT_W'(rfrac);
   assign ad    = (rfrac >= HALF_Q16) ? (rfrac - HALF_Q16) : (HALF_Q16 - rfrac);
   assign dd    = 32'(ad) * 32'(ad);
   assign lo2   = 34'(lo) * 34'(lo);
   assign hi2   = 34'(rfrac) * 34'(rfrac);

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         raw[k]     = '0;
         wgt_o[k]   = '0;
         use_tap[k] = 1'b0;
      end
      case (mode_i)
         MODE_NGP: begin
            raw[0]     = c_raw;
            wgt_o[0]   = ONE_Q16;
            use_tap[0] = 1'b1;
         end
         MODE_CIC: begin
            raw[0]     = f_raw;
            raw[1]     = f_raw + XW'(1);
            wgt_o[0]   = ONE_Q16 - WGT_W'(frac);
            wgt_o[1]   = WGT_W'(frac);
            use_tap[0] = 1'b1;
            use_tap[1] = 1'b1;
         end
         MODE_TSC: begin
            raw[0]     = c_raw - XW'(1);
            raw[1]     = c_raw;
            raw[2]     = c_raw + XW'(1);
            wgt_o[0]   = WGT_W'(lo2 >> 17);
            wgt_o[1]   = TSC_MID - WGT_W'(dd >> 16);
            wgt_o[2]   = WGT_W'(hi2 >> 17);
            use_tap[0] = 1'b1;
            use_tap[1] = 1'b1;
            use_tap[2] = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         wr[k]    = wrap(raw[k], gx);
         ok_o[k]  = use_tap[k] && (wr[k] < gx);
         idx_o[k] = wr[k][IW-1:0];
      end
   end

endmodule

>>> design/particle_mesh_mass_deposit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_mesh_mass_deposit
// NGP / CIC / TSC mass deposit onto one z slab of a periodic grid, with
// read-and-clear of single cells.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_op req_pos_x/y/z req_cell_addr      start & !busy
//  result    rsp_cell_value rsp_cell_addr_out        rsp_valid, one cycle
//  config    csr_index csr_wdata                     csr_we, no wait
//
// A deposit runs ST_MUL, where one shared 32x32 multiplier scales the three
// axes, then ST_TAPS, where one cell a cycle (n^3 cells, n = 1, 2, 3 taps
// per axis) goes through a read-modify-write pipeline on the single grid
// memory, then ST_DRAIN. A read runs ST_RD_LIM, ST_RD_ISSUE and ST_RD_DATA;
// the result appears in ST_RD_DATA. After reset the grid is cleared, one cell
// a cycle, over all GRID_MAX^2*SLAB_MAX cells (262144 by default); busy stays
// high meanwhile. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module particle_mesh_mass_deposit #(
   parameter int GRID_MAX = pmd_pkg::GRID_MAX_DEF,
   parameter int SLAB_MAX = pmd_pkg::SLAB_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [pmd_pkg::POS_W-1:0]     req_pos_x,
   input  logic [pmd_pkg::POS_W-1:0]     req_pos_y,
   input  logic [pmd_pkg::POS_W-1:0]     req_pos_z,
   input  logic [pmd_pkg::CADDR_W-1:0]   req_cell_addr,
   output logic                          rsp_valid,
   output logic [pmd_pkg::VAL_W-1:0]     rsp_cell_value,
   output logic [pmd_pkg::CADDR_W-1:0]   rsp_cell_addr_out,
   input  logic                          csr_we,
   input  logic [pmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pmd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pmd_pkg::*;

   localparam int STORE = GRID_MAX * GRID_MAX * SLAB_MAX;
   localparam int AW    = $clog2(STORE);
   localparam int GW    = $clog2(GRID_MAX + 1);
   localparam int IW    = $clog2(GRID_MAX);
   localparam int DW    = $clog2(SLAB_MAX + 1);
   localparam int SW    = (SLAB_MAX > 1) ? $clog2(SLAB_MAX) : 1;
   localparam int YZW   = $clog2(GRID_MAX * SLAB_MAX + 1);
   localparam int GGW   = 2 * GW;

   // configuration
   logic [MODE_W-1:0]   mode_ff;
   logic [GSIZE_W-1:0]  gsize_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [SSTART_W-1:0] sstart_ff;
   logic [SDEPTH_W-1:0] sdepth_ff;

   // control
   state_type           state_ff, state_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [1:0]          a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [AW-1:0]       clr_ff;
   logic                p1_v_ff, p2_v_ff, p3_v_ff;
   logic                last_we_ff;
   logic                ok_ff;

   // payload
   logic                req_op_ff;
   logic [POS_W-1:0]    px_ff, py_ff, pz_ff;
   logic [CADDR_W-1:0]  raddr_ff;
   logic [T_W-1:0]      t_ff;
   logic [IW-1:0]       ix_ff [0:TAPS-1];
   logic [IW-1:0]       iy_ff [0:TAPS-1];
   logic [IW-1:0]       iz_ff [0:TAPS-1];
   logic                okx_ff [0:TAPS-1];
   logic                oky_ff [0:TAPS-1];
   logic                okz_ff [0:TAPS-1];
   logic [WGT_W-1:0]    wx_ff [0:TAPS-1];
   logic [WGT_W-1:0]    wy_ff [0:TAPS-1];
   logic [WGT_W-1:0]    wz_ff [0:TAPS-1];
   logic [WGT_W-1:0]    p1_wxy_ff, p1_wz_ff, p2_wt_ff, p3_wt_ff;
   logic [IW-1:0]       p1_ix_ff;
   logic [YZW-1:0]      p1_yz_ff;
   logic [AW-1:0]       p2_addr_ff, p3_addr_ff, last_wa_ff;
   logic [VAL_W-1:0]    last_wd_ff;
   logic [GGW-1:0]      gg_ff;

   // effective grid and depth
   logic [8:0]          g9, d9;
   logic [GW-1:0]       g_eff;
   logic [DW-1:0]       d_eff;

   always_comb begin
      g9 = {2'b0, gsize_ff};
      if (g9 < 9'd2) begin
         g9 = 9'd2;
      end else if (g9 > 9'(GRID_MAX)) begin
         g9 = 9'(GRID_MAX);
      end
      d9 = {2'b0, sdepth_ff};
      if (d9 < 9'd1) begin
         d9 = 9'd1;
      end else if (d9 > 9'(SLAB_MAX)) begin
         d9 = 9'(SLAB_MAX);
      end
   end

   assign g_eff = g9[GW-1:0];
   assign d_eff = d9[DW-1:0];

   // axis scaling and taps
   logic [POS_W-1:0]    pos_sel;
   logic [63:0]         prod;
   logic [IW-1:0]       ax_idx [0:TAPS-1];
   logic                ax_ok  [0:TAPS-1];
   logic [WGT_W-1:0]    ax_wgt [0:TAPS-1];

   always_comb begin
      case (cnt_ff)
         2'd0:    pos_sel = px_ff;
         2'd1:    pos_sel = py_ff;
         default: pos_sel = pz_ff;
      endcase
   end

   assign prod = 64'(pos_sel) * 64'(scale_ff);

   pmd_axis #(.GRID_MAX(GRID_MAX)) u_axis (
      .t_i    (t_ff),
      .mode_i (mode_ff),
      .g_i    (g_eff),
      .idx_o  (ax_idx),
      .ok_o   (ax_ok),
      .wgt_o  (ax_wgt)
   );

   // tap generator and slab check
   logic                last_tap;
   logic [9:0]          zsd;
   logic                zs_ok;
   logic                tap_v;
   logic [SW-1:0]       zs;

   assign last_tap = (a_ff == mode_ff) && (b_ff == mode_ff) && (c_ff == mode_ff);
   assign zsd      = 10'(iz_ff[c_ff]) - 10'(sstart_ff);
   assign zs_ok    = !zsd[9] && (zsd[8:0] < 9'(d_eff));
   assign zs       = zsd[SW-1:0];
   assign tap_v    = (state_ff == ST_TAPS) && okx_ff[a_ff] && oky_ff[b_ff]
                     && okz_ff[c_ff] && zs_ok;

   // read-modify-write
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [VAL_W-1:0]    ram_wdata, ram_rdata;
   logic [VAL_W-1:0]    old_val;
   logic [VAL_W:0]      sum;
   logic [VAL_W-1:0]    sat_val;

   // forward the cell written last cycle: its read saw the old content
   assign old_val = (last_we_ff && (last_wa_ff == p3_addr_ff)) ? last_wd_ff : ram_rdata;
   assign sum     = (VAL_W + 1)'(old_val) + (VAL_W + 1)'(p3_wt_ff);
   assign sat_val = sum[VAL_W] ? '1 : sum[VAL_W-1:0];

   pmd_ram #(.WIDTH(VAL_W), .DEPTH(STORE)) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(STORE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_READ) begin
                  state_in = ST_RD_LIM;
               end else if (mode_ff == MODE_NGP || mode_ff == MODE_CIC
                            || mode_ff == MODE_TSC) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == 2'd3) begin
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == 2'd2) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_LIM:   state_in = ST_RD_ISSUE;
         ST_RD_ISSUE: state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      cnt_in = (state_ff == ST_MUL || state_ff == ST_DRAIN) ? cnt_ff + 2'd1 : 2'd0;
      a_in   = 2'd0;
      b_in   = 2'd0;
      c_in   = 2'd0;
      if (state_ff == ST_TAPS) begin
         a_in = a_ff + 2'd1;
         b_in = b_ff;
         c_in = c_ff;
         if (a_ff == mode_ff) begin
            a_in = 2'd0;
            b_in = b_ff + 2'd1;
            if (b_ff == mode_ff) begin
               b_in = 2'd0;
               c_in = c_ff + 2'd1;
            end
         end
      end
   end

   // outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_RD_DATA);
      ram_raddr = (state_ff == ST_RD_ISSUE) ? AW'(raddr_ff) : p2_addr_ff;
      ram_we    = 1'b0;
      ram_waddr = p3_addr_ff;
      ram_wdata = sat_val;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_RD_DATA) begin
         ram_we    = ok_ff;
         ram_waddr = AW'(raddr_ff);
         ram_wdata = '0;
      end else if (p3_v_ff) begin
         ram_we = 1'b1;
      end
   end

   assign rsp_cell_value    = ok_ff ? ram_rdata : '0;
   assign rsp_cell_addr_out = raddr_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= 2'd0;
         a_ff       <= 2'd0;
         b_ff       <= 2'd0;
         c_ff       <= 2'd0;
         clr_ff     <= '0;
         p1_v_ff    <= 1'b0;
         p2_v_ff    <= 1'b0;
         p3_v_ff    <= 1'b0;
         last_we_ff <= 1'b0;
         ok_ff      <= 1'b0;
         mode_ff    <= MODE_RST;
         gsize_ff   <= GSIZE_RST;
         scale_ff   <= SCALE_RST;
         sstart_ff  <= SSTART_RST;
         sdepth_ff  <= SDEPTH_RST;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         a_ff       <= a_in;
         b_ff       <= b_in;
         c_ff       <= c_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
         p1_v_ff    <= tap_v;
         p2_v_ff    <= p1_v_ff;
         p3_v_ff    <= p2_v_ff;
         last_we_ff <= ram_we;
         if (state_ff == ST_RD_ISSUE) begin
            ok_ff <= (32'(raddr_ff) < 32'(gg_ff) * 32'(d_eff));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ASSIGN_MODE: mode_ff   <= csr_wdata[MODE_W-1:0];
               CSR_GRID_SIZE:   gsize_ff  <= csr_wdata[GSIZE_W-1:0];
               CSR_CELL_SCALE:  scale_ff  <= csr_wdata[SCALE_W-1:0];
               CSR_SLAB_START:  sstart_ff <= csr_wdata[SSTART_W-1:0];
               CSR_SLAB_DEPTH:  sdepth_ff <= csr_wdata[SDEPTH_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_op_ff <= req_op;
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         pz_ff     <= req_pos_z;
         raddr_ff  <= req_cell_addr;
      end
      if (state_ff == ST_MUL) begin
         t_ff <= prod[T_W+15:16];
         case (cnt_ff)
            2'd1: begin
               ix_ff  <= ax_idx;
               okx_ff <= ax_ok;
               wx_ff  <= ax_wgt;
            end
            2'd2: begin
               iy_ff  <= ax_idx;
               oky_ff <= ax_ok;
               wy_ff  <= ax_wgt;
            end
            2'd3: begin
               iz_ff  <= ax_idx;
               okz_ff <= ax_ok;
               wz_ff  <= ax_wgt;
            end
            default: begin
            end
         endcase
      end
      gg_ff      <= GGW'(g_eff) * GGW'(g_eff);
      p1_wxy_ff  <= WGT_W'((34'(wx_ff[a_ff]) * 34'(wy_ff[b_ff])) >> 16);
      p1_wz_ff   <= wz_ff[c_ff];
      p1_ix_ff   <= ix_ff[a_ff];
      p1_yz_ff   <= YZW'(32'(iy_ff[b_ff]) + 32'(g_eff) * 32'(zs));
      p2_wt_ff   <= WGT_W'((34'(p1_wxy_ff) * 34'(p1_wz_ff)) >> 16);
      p2_addr_ff <= AW'(32'(p1_ix_ff) + 32'(g_eff) * 32'(p1_yz_ff));
      p3_wt_ff   <= p2_wt_ff;
      p3_addr_ff <= p2_addr_ff;
      last_wa_ff <= ram_waddr;
      last_wd_ff <= ram_wdata;
   end

`ifndef SYNTH
   // a new request never finds cell updates still in flight
   a_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> (!p1_v_ff && !p2_v_ff && !p3_v_ff))
      else $error("request accepted with deposit pipeline busy");

   // one result per read request
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // results only come from read requests
   a_rsp_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (req_op_ff == OP_READ))
      else $error("result issued for a deposit");

   // an out-of-range read leaves the grid untouched
   a_no_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_DATA && !ok_ff) |-> !ram_we)
      else $error("grid written on out-of-range read");
`endif

endmodule
